/* rtl/et_pkg.sv */
// shared types, character codes and classification functions for the expression tokenizer
package et_pkg;

    // token kinds as they appear on the result port
    typedef enum logic [3:0] {
        KIND_NUM     = 4'd0,
        KIND_IDENT   = 4'd1,
        KIND_VAR     = 4'd2,
        KIND_INT     = 4'd3,
        KIND_PRINT   = 4'd4,
        KIND_PLUS    = 4'd5,
        KIND_MINUS   = 4'd6,
        KIND_STAR    = 4'd7,
        KIND_SLASH   = 4'd8,
        KIND_PERCENT = 4'd9,
        KIND_LPAREN  = 4'd10,
        KIND_RPAREN  = 4'd11,
        KIND_SEMI    = 4'd12,
        KIND_ASSIGN  = 4'd13,
        KIND_END     = 4'd14,
        KIND_ERROR   = 4'd15
    } kind_t;

    // scan mode between bytes
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_WORD
    } mode_t;

    // controller states
    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_DECIDE,
        ST_START,
        ST_REPLAY,
        ST_HALT
    } state_t;

    // source of an emitted result word
    typedef enum logic [1:0] {
        EMIT_NUM,
        EMIT_KEYWORD,
        EMIT_IDENT,
        EMIT_BYTE
    } emit_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic      capture;
        logic      acc_start;
        logic      acc_step;
        logic      word_start;
        logic      word_append;
        logic      rd_start;
        logic      rd_adv;
        logic      emit;
        emit_sel_t emit_sel;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_space;
        logic is_zero;
        logic is_digit;
        logic is_word_start;
        logic is_word_char;
        logic is_op;
        logic is_keyword;
        logic replay_last;
        logic out_free;
    } status_t;

    // character codes
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_ASSIGN  = 8'h3D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // keyword letters
    localparam logic [7:0] CH_V = 8'h76;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_I = 8'h69;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_P = 8'h70;

    // largest number value
    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // operator kind, error kind for anything else
    function automatic kind_t op_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_PLUS:    k = KIND_PLUS;
            CH_MINUS:   k = KIND_MINUS;
            CH_STAR:    k = KIND_STAR;
            CH_SLASH:   k = KIND_SLASH;
            CH_PERCENT: k = KIND_PERCENT;
            CH_LPAREN:  k = KIND_LPAREN;
            CH_RPAREN:  k = KIND_RPAREN;
            CH_SEMI:    k = KIND_SEMI;
            CH_ASSIGN:  k = KIND_ASSIGN;
            default:    k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

/* rtl/et_ram.sv */
// generic single write port ram with registered read
module et_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/et_ctrl.sv */
// tokenizer controller: scan mode and sequencing of accept, flush, replay and emit
module et_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  et_pkg::status_t  sts,
    output et_pkg::cmd_t     cmd
);

    et_pkg::state_t state_reg, state_next;
    et_pkg::mode_t  mode_reg, mode_next;

    // state and mode registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= et_pkg::ST_ACCEPT;
            mode_reg  <= et_pkg::MODE_IDLE;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    // next state and commands
    always_comb begin
        logic run_start;
        run_start  = 1'b0;
        state_next = state_reg;
        mode_next  = mode_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.emit_sel = et_pkg::EMIT_BYTE;

        case (state_reg)
            et_pkg::ST_ACCEPT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = et_pkg::ST_DECIDE;
                end
            end
            et_pkg::ST_DECIDE: begin
                case (mode_reg)
                    et_pkg::MODE_NUM: begin
                        if (sts.is_digit) begin
                            cmd.acc_step = 1'b1;
                            state_next   = et_pkg::ST_ACCEPT;
                        end else if (sts.out_free) begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = et_pkg::EMIT_NUM;
                            mode_next    = et_pkg::MODE_IDLE;
                            state_next   = et_pkg::ST_START;
                        end
                    end
                    et_pkg::MODE_WORD: begin
                        if (sts.is_word_char) begin
                            cmd.word_append = 1'b1;
                            state_next      = et_pkg::ST_ACCEPT;
                        end else if (sts.is_keyword) begin
                            if (sts.out_free) begin
                                cmd.emit     = 1'b1;
                                cmd.emit_sel = et_pkg::EMIT_KEYWORD;
                                mode_next    = et_pkg::MODE_IDLE;
                                state_next   = et_pkg::ST_START;
                            end
                        end else begin
                            // first stored character is read for the replay
                            cmd.rd_start = 1'b1;
                            state_next   = et_pkg::ST_REPLAY;
                        end
                    end
                    default: begin
                        run_start = 1'b1;
                    end
                endcase
            end
            et_pkg::ST_START: begin
                run_start = 1'b1;
            end
            et_pkg::ST_REPLAY: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = et_pkg::EMIT_IDENT;
                    cmd.rd_adv   = 1'b1;
                    if (sts.replay_last) begin
                        mode_next  = et_pkg::MODE_IDLE;
                        state_next = et_pkg::ST_START;
                    end
                end
            end
            et_pkg::ST_HALT: begin
                // bytes are taken and dropped until reset
                s_ready = 1'b1;
            end
            default: begin
                state_next = et_pkg::ST_ACCEPT;
            end
        endcase

        // handling of a byte from idle
        if (run_start) begin
            if (sts.is_space) begin
                state_next = et_pkg::ST_ACCEPT;
            end else if (sts.is_digit) begin
                cmd.acc_start = 1'b1;
                mode_next     = et_pkg::MODE_NUM;
                state_next    = et_pkg::ST_ACCEPT;
            end else if (sts.is_word_start) begin
                cmd.word_start = 1'b1;
                mode_next      = et_pkg::MODE_WORD;
                state_next     = et_pkg::ST_ACCEPT;
            end else if (sts.out_free) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = et_pkg::EMIT_BYTE;
                state_next   = (sts.is_zero || sts.is_op) ? et_pkg::ST_ACCEPT
                                                          : et_pkg::ST_HALT;
            end
        end
    end

    // a result word is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("emit into a full output register");

    // an error halts the block until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == et_pkg::ST_HALT |=> state_reg == et_pkg::ST_HALT)
        else $error("left halt without reset");

    // replay only happens for a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == et_pkg::ST_REPLAY |-> mode_reg == et_pkg::MODE_WORD)
        else $error("replay outside word mode");

    // a word start never comes with a result in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.word_start |-> !cmd.emit)
        else $error("word start together with an emit");

endmodule

/* rtl/et_dp.sv */
// tokenizer datapath: byte register, number accumulator, word store and output register
module et_dp #(
    parameter int WORD_BUFFER_BYTES = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  et_pkg::cmd_t     cmd,
    output et_pkg::status_t  sts,
    input  logic [7:0]       s_ch,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [3:0]       m_kind,
    output logic [30:0]      m_number_value,
    output logic             m_overflowed,
    output logic [7:0]       m_text_char,
    output logic             m_last
);

    localparam int LEN_W = $clog2(WORD_BUFFER_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(WORD_BUFFER_BYTES - 1);

    logic [7:0]       ch_reg;
    logic [30:0]      acc_reg, acc_next;
    logic             sat_reg, sat_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             var_ok_reg, var_ok_next;
    logic             int_ok_reg, int_ok_next;
    logic             print_ok_reg, print_ok_next;
    logic [LEN_W-1:0] rd_idx_reg, rd_idx_next;

    logic             m_valid_reg, m_valid_next;
    et_pkg::kind_t    kind_reg, kind_next;
    logic [30:0]      value_reg, value_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;

    logic             ram_we;
    logic [LEN_W-1:0] ram_waddr;
    logic             ram_re;
    logic [LEN_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    logic [34:0]      acc_x10;
    logic             len_full;
    logic [LEN_W-1:0] rd_idx_inc;
    et_pkg::kind_t    byte_kind;
    et_pkg::kind_t    kw_kind;

    // byte classification
    always_comb begin
        sts.is_space      = et_pkg::is_space(ch_reg);
        sts.is_zero       = (ch_reg == et_pkg::CH_NUL);
        sts.is_digit      = et_pkg::is_digit(ch_reg);
        sts.is_word_start = et_pkg::is_alpha(ch_reg) || (ch_reg == et_pkg::CH_UNDER);
        sts.is_word_char  = sts.is_word_start || sts.is_digit;
        sts.is_op         = (et_pkg::op_kind(ch_reg) != et_pkg::KIND_ERROR);
        sts.is_keyword    = ((len_reg == LEN_W'(3)) && (var_ok_reg || int_ok_reg))
                          || ((len_reg == LEN_W'(5)) && print_ok_reg);
        sts.replay_last   = (rd_idx_inc == len_reg);
        sts.out_free      = !m_valid_reg || m_ready;
    end

    assign rd_idx_inc = rd_idx_reg + LEN_W'(1);
    assign len_full   = (len_reg == MAX_LEN);

    // decimal accumulate with saturation
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {31'b0, ch_reg[3:0]};

    always_comb begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (cmd.acc_start) begin
            acc_next = {27'b0, ch_reg[3:0]};
            sat_next = 1'b0;
        end else if (cmd.acc_step) begin
            if (sat_reg || (acc_x10 > {4'b0, et_pkg::NUM_MAX})) begin
                acc_next = et_pkg::NUM_MAX;
                sat_next = 1'b1;
            end else begin
                acc_next = acc_x10[30:0];
            end
        end
    end

    // word store control and keyword prefix tracking
    always_comb begin
        len_next      = len_reg;
        var_ok_next   = var_ok_reg;
        int_ok_next   = int_ok_reg;
        print_ok_next = print_ok_reg;
        ram_we        = 1'b0;
        ram_waddr     = len_reg;
        if (cmd.word_start) begin
            ram_we        = 1'b1;
            ram_waddr     = '0;
            len_next      = LEN_W'(1);
            var_ok_next   = (ch_reg == et_pkg::CH_V);
            int_ok_next   = (ch_reg == et_pkg::CH_I);
            print_ok_next = (ch_reg == et_pkg::CH_P);
        end else if (cmd.word_append && !len_full) begin
            ram_we        = 1'b1;
            len_next      = len_reg + LEN_W'(1);
            var_ok_next   = var_ok_reg
                && (((len_reg == LEN_W'(1)) && (ch_reg == et_pkg::CH_A))
                 || ((len_reg == LEN_W'(2)) && (ch_reg == et_pkg::CH_R)));
            int_ok_next   = int_ok_reg
                && (((len_reg == LEN_W'(1)) && (ch_reg == et_pkg::CH_N))
                 || ((len_reg == LEN_W'(2)) && (ch_reg == et_pkg::CH_T)));
            print_ok_next = print_ok_reg
                && (((len_reg == LEN_W'(1)) && (ch_reg == et_pkg::CH_R))
                 || ((len_reg == LEN_W'(2)) && (ch_reg == et_pkg::CH_I))
                 || ((len_reg == LEN_W'(3)) && (ch_reg == et_pkg::CH_N))
                 || ((len_reg == LEN_W'(4)) && (ch_reg == et_pkg::CH_T)));
        end
    end

    // replay read pointer
    always_comb begin
        rd_idx_next = rd_idx_reg;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        if (cmd.rd_start) begin
            rd_idx_next = '0;
            ram_re      = 1'b1;
        end else if (cmd.rd_adv) begin
            rd_idx_next = rd_idx_inc;
            ram_re      = 1'b1;
            ram_raddr   = rd_idx_inc;
        end
    end

    et_ram #(
        .WIDTH(8),
        .DEPTH(WORD_BUFFER_BYTES)
    ) u_word_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ch_reg),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // kinds for single-word tokens
    always_comb begin
        if (sts.is_zero) begin
            byte_kind = et_pkg::KIND_END;
        end else begin
            byte_kind = et_pkg::op_kind(ch_reg);
        end
        if ((len_reg == LEN_W'(3)) && var_ok_reg) begin
            kw_kind = et_pkg::KIND_VAR;
        end else if ((len_reg == LEN_W'(3)) && int_ok_reg) begin
            kw_kind = et_pkg::KIND_INT;
        end else begin
            kw_kind = et_pkg::KIND_PRINT;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        value_next   = value_reg;
        ovf_next     = ovf_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            value_next   = '0;
            ovf_next     = 1'b0;
            char_next    = '0;
            last_next    = 1'b1;
            case (cmd.emit_sel)
                et_pkg::EMIT_NUM: begin
                    kind_next  = et_pkg::KIND_NUM;
                    value_next = acc_reg;
                    ovf_next   = sat_reg;
                end
                et_pkg::EMIT_KEYWORD: begin
                    kind_next = kw_kind;
                end
                et_pkg::EMIT_IDENT: begin
                    kind_next = et_pkg::KIND_IDENT;
                    char_next = ram_rdata;
                    last_next = sts.replay_last;
                end
                default: begin
                    kind_next = byte_kind;
                    if (byte_kind == et_pkg::KIND_ERROR) begin
                        char_next = ch_reg;
                    end
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            acc_reg      <= '0;
            sat_reg      <= 1'b0;
            len_reg      <= '0;
            var_ok_reg   <= 1'b0;
            int_ok_reg   <= 1'b0;
            print_ok_reg <= 1'b0;
            rd_idx_reg   <= '0;
        end else begin
            m_valid_reg  <= m_valid_next;
            acc_reg      <= acc_next;
            sat_reg      <= sat_next;
            len_reg      <= len_next;
            var_ok_reg   <= var_ok_next;
            int_ok_reg   <= int_ok_next;
            print_ok_reg <= print_ok_next;
            rd_idx_reg   <= rd_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ch_reg <= s_ch;
        end
        kind_reg  <= kind_next;
        value_reg <= value_next;
        ovf_reg   <= ovf_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_number_value = value_reg;
    assign m_overflowed   = ovf_reg;
    assign m_text_char    = char_reg;
    assign m_last         = last_reg;

    // stored word never grows past the buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= MAX_LEN)
        else $error("word length beyond buffer");

    // only identifier characters may be non-final words of a token
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (kind_reg != et_pkg::KIND_IDENT) |-> last_reg)
        else $error("single-word token without last");

    // overflow flag only on number tokens
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ovf_reg |-> kind_reg == et_pkg::KIND_NUM)
        else $error("overflow flag on a non-number token");

endmodule

/* rtl/expression_tokenizer.sv */
// expression tokenizer top level: controller plus datapath
// Takes one source byte per word on s_ and emits token words on m_. A byte is
// taken in one cycle and classified in the next. A number or keyword is emitted
// when the byte that closes it is classified, and an identifier's kept characters
// are then replayed from the word buffer ram, whose single read port delivers one
// character per cycle while the output register is free. The byte that closes a
// token is handled in the start state that follows, and a token it makes of its
// own is emitted from that state. The output register lets the next byte be taken
// while a result word waits for m_ready; back-pressure stalls only the steps that
// emit. After an error token the block takes and drops every byte until reset.
module expression_tokenizer #(
    parameter int WORD_BUFFER_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_kind,
    output logic [30:0] m_number_value,
    output logic        m_overflowed,
    output logic [7:0]  m_text_char,
    output logic        m_last
);

    et_pkg::cmd_t    cmd;
    et_pkg::status_t sts;

    et_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    et_dp #(
        .WORD_BUFFER_BYTES(WORD_BUFFER_BYTES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_ch          (s_ch),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_number_value(m_number_value),
        .m_overflowed  (m_overflowed),
        .m_text_char   (m_text_char),
        .m_last        (m_last)
    );

endmodule

/* bench/tb_expression_tokenizer.sv */
// testbench for the expression tokenizer: byte stream in, token words checked against a predictor
`timescale 1ns / 1ps

// one expected token word
typedef struct {
    et_pkg::kind_t kind;
    logic [30:0]   value;
    logic          ovf;
    logic [7:0]    text;
    logic          last;
} token_word_t;

typedef enum {SCAN_IDLE, SCAN_NUM, SCAN_WORD, SCAN_HALT} scan_t;

typedef enum {READY_OPEN, READY_COIN, READY_SPARSE, READY_TOGGLE} ready_pattern_t;

// lexer predictor plus the queue of token words still owed by the block
class token_ledger;
    token_word_t pending_tokens[$];
    scan_t       scan;
    logic [30:0] accum;
    logic        saturated;
    logic [7:0]  word_buf[$];
    int          keep_max;
    int          mismatches;
    logic [7:0]  op_bytes[9] = '{et_pkg::CH_PLUS, et_pkg::CH_MINUS, et_pkg::CH_STAR,
                                 et_pkg::CH_SLASH, et_pkg::CH_PERCENT, et_pkg::CH_LPAREN,
                                 et_pkg::CH_RPAREN, et_pkg::CH_SEMI, et_pkg::CH_ASSIGN};

    function new(int buffer_bytes);
        keep_max   = buffer_bytes - 1;
        scan       = SCAN_IDLE;
        accum      = '0;
        saturated  = 1'b0;
        mismatches = 0;
    endfunction

    function bit is_dec(logic [7:0] c);
        return c >= et_pkg::CH_ZERO && c <= et_pkg::CH_NINE;
    endfunction

    function bit is_letter(logic [7:0] c);
        return (c >= et_pkg::CH_LOW_A && c <= et_pkg::CH_LOW_Z) ||
               (c >= et_pkg::CH_UP_A && c <= et_pkg::CH_UP_Z) ||
               c == et_pkg::CH_UNDER;
    endfunction

    function bit is_blank(logic [7:0] c);
        return c == et_pkg::CH_SPACE || (c >= et_pkg::CH_TAB && c <= et_pkg::CH_CR);
    endfunction

    function void push_token(et_pkg::kind_t k, logic [30:0] v, logic o, logic [7:0] t,
                             logic l);
        token_word_t w;
        w.kind  = k;
        w.value = v;
        w.ovf   = o;
        w.text  = t;
        w.last  = l;
        pending_tokens.push_back(w);
    endfunction

    function bit word_is(string s);
        if (word_buf.size() != s.len())
            return 1'b0;
        foreach (word_buf[i])
            if (word_buf[i] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // keyword token, or the kept characters one per word
    function void close_word();
        if (word_is("var"))
            push_token(et_pkg::KIND_VAR, '0, 1'b0, 8'h00, 1'b1);
        else if (word_is("int"))
            push_token(et_pkg::KIND_INT, '0, 1'b0, 8'h00, 1'b1);
        else if (word_is("print"))
            push_token(et_pkg::KIND_PRINT, '0, 1'b0, 8'h00, 1'b1);
        else
            foreach (word_buf[i])
                push_token(et_pkg::KIND_IDENT, '0, 1'b0, word_buf[i],
                           i == word_buf.size() - 1);
        word_buf.delete();
    endfunction

    // advance the lexer by one accepted byte
    function void note_byte(logic [7:0] c);
        longint unsigned grown;
        if (scan == SCAN_HALT)
            return;
        // an open number or word either grows or is closed by this byte
        if (scan == SCAN_NUM) begin
            if (is_dec(c)) begin
                grown = longint'(accum) * 10 + (c - et_pkg::CH_ZERO);
                if (saturated || grown > et_pkg::NUM_MAX) begin
                    accum     = et_pkg::NUM_MAX;
                    saturated = 1'b1;
                end else begin
                    accum = grown[30:0];
                end
                return;
            end
            push_token(et_pkg::KIND_NUM, accum, saturated, 8'h00, 1'b1);
            scan      = SCAN_IDLE;
            accum     = '0;
            saturated = 1'b0;
        end else if (scan == SCAN_WORD) begin
            if (is_letter(c) || is_dec(c)) begin
                if (word_buf.size() < keep_max)
                    word_buf.push_back(c);
                return;
            end
            close_word();
            scan = SCAN_IDLE;
        end
        // same byte handled from idle
        if (is_blank(c))
            return;
        if (c == et_pkg::CH_NUL) begin
            push_token(et_pkg::KIND_END, '0, 1'b0, 8'h00, 1'b1);
            return;
        end
        if (is_dec(c)) begin
            scan      = SCAN_NUM;
            accum     = 31'(c - et_pkg::CH_ZERO);
            saturated = 1'b0;
            return;
        end
        if (is_letter(c)) begin
            scan = SCAN_WORD;
            word_buf.delete();
            word_buf.push_back(c);
            return;
        end
        for (int i = 0; i < 9; i++)
            if (op_bytes[i] == c) begin
                push_token(et_pkg::kind_t'(et_pkg::KIND_PLUS + i), '0, 1'b0, 8'h00, 1'b1);
                return;
            end
        // anything else stops the lexer for good
        scan = SCAN_HALT;
        push_token(et_pkg::KIND_ERROR, '0, 1'b0, c, 1'b1);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    // compare one accepted result word with the oldest expected token word
    function void check_token(logic [3:0] kind, logic [30:0] value, logic ovf,
                              logic [7:0] text, logic last);
        token_word_t want;
        if (pending_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: unexpected token word, expected none actual kind %0d",
                         $time, kind);
            return;
        end
        want = pending_tokens.pop_front();
        if (kind !== want.kind)
            report("kind", 32'(want.kind), 32'(kind));
        if (value !== want.value)
            report("number_value", 32'(want.value), 32'(value));
        if (ovf !== want.ovf)
            report("overflowed", 32'(want.ovf), 32'(ovf));
        if (text !== want.text)
            report("text_char", 32'(want.text), 32'(text));
        if (last !== want.last)
            report("last", 32'(want.last), 32'(last));
    endfunction
endclass

module tb_expression_tokenizer;
    localparam int WORD_BYTES    = 64;
    localparam int RANDOM_BYTES  = 260;
    localparam int SETTLE_CYCLES = 200;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_ch    = 8'h00;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [3:0]  m_kind;
    logic [30:0] m_number_value;
    logic        m_overflowed;
    logic [7:0]  m_text_char;
    logic        m_last;

    token_ledger    ledger;
    int             bytes_taken = 0;
    int             burst_left  = 8;
    bit             valid_up    = 1'b0;
    ready_pattern_t ready_mode  = READY_OPEN;
    int             ready_left  = 0;
    int             ready_phase = 0;

    string      keywords[3]   = '{"var", "int", "print"};
    string      near_words[6] = '{"variable", "in", "prints", "Var", "int_", "print9"};
    logic [7:0] op_bytes[9]   = '{et_pkg::CH_PLUS, et_pkg::CH_MINUS, et_pkg::CH_STAR,
                                  et_pkg::CH_SLASH, et_pkg::CH_PERCENT, et_pkg::CH_LPAREN,
                                  et_pkg::CH_RPAREN, et_pkg::CH_SEMI, et_pkg::CH_ASSIGN};

    expression_tokenizer #(.WORD_BUFFER_BYTES(WORD_BYTES)) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_number_value (m_number_value),
        .m_overflowed   (m_overflowed),
        .m_text_char    (m_text_char),
        .m_last         (m_last)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: check accepted words, then choose the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            ledger.check_token(m_kind, m_number_value, m_overflowed, m_text_char, m_last);
        if (ready_left <= 0) begin
            ready_mode = ready_pattern_t'($urandom_range(0, 3));
            ready_left = $urandom_range(10, 80);
        end
        ready_left--;
        ready_phase++;
        case (ready_mode)
            READY_OPEN:   m_ready <= 1'b1;
            READY_COIN:   m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_ready <= ($urandom_range(0, 4) == 0);
            default:      m_ready <= ready_phase[1];
        endcase
    end

    task automatic drop_valid();
        if (valid_up) begin
            s_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // present one byte, hold it until taken, then pace the burst
    task automatic send_byte(input logic [7:0] c);
        s_valid <= 1'b1;
        s_ch    <= c;
        valid_up = 1'b1;
        do @(posedge aclk); while (!s_ready);
        ledger.note_byte(c);
        bytes_taken++;
        burst_left--;
        if (burst_left <= 0) begin
            drop_valid();
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    // hold off until every expected word has come back
    task automatic wait_for_drain();
        drop_valid();
        do @(posedge aclk); while (ledger.pending_tokens.size() != 0);
    endtask

    function automatic logic [7:0] word_byte(bit lead);
        int pick;
        pick = $urandom_range(0, lead ? 52 : 62);
        if (pick < 26)
            return 8'(et_pkg::CH_LOW_A + pick);
        if (pick < 52)
            return 8'(et_pkg::CH_UP_A + pick - 26);
        if (pick == 52)
            return et_pkg::CH_UNDER;
        return 8'(et_pkg::CH_ZERO + pick - 53);
    endfunction

    task automatic send_word(input int len);
        send_byte(word_byte(1'b1));
        repeat (len - 1)
            send_byte(word_byte(1'b0));
    endtask

    task automatic send_digits(input int len);
        repeat (len)
            send_byte(8'(et_pkg::CH_ZERO + $urandom_range(0, 9)));
    endtask

    // one random token or separator of well-formed source text
    task automatic send_random_token();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(0, 99);
        if (pick < 25) begin
            if (len < 5)
                send_text(len[0] ? "2147483647" : "2147483648");
            else if (len < 20)
                send_digits($urandom_range(11, 22));
            else
                send_digits($urandom_range(1, 10));
        end else if (pick < 50) begin
            if (len < 20)
                send_text(keywords[$urandom_range(0, 2)]);
            else if (len < 30)
                send_text(near_words[$urandom_range(0, 5)]);
            else if (len < 33)
                send_word($urandom_range(60, 70));
            else
                send_word($urandom_range(1, 8));
        end else if (pick < 75) begin
            send_byte(op_bytes[$urandom_range(0, 8)]);
        end else if (pick < 96) begin
            repeat ($urandom_range(1, 3)) begin
                len = $urandom_range(9, 14);
                send_byte(len == 14 ? et_pkg::CH_SPACE : 8'(len));
            end
        end else begin
            send_byte(et_pkg::CH_NUL);
        end
    endtask

    // stimulus and end of run
    initial begin
        int  random_start;
        bit  drained_mid;
        drained_mid = 1'b0;
        ledger = new(WORD_BYTES);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // keywords, all operators, token closed by the next byte, keyword closed by end
        send_text("var\tprint(_Z9+0)-*/%;=int");
        send_byte(et_pkg::CH_NUL);
        wait_for_drain();

        // number and word limits, then random source text
        random_start = bytes_taken;
        send_text("2147483647 2147483648 ");
        send_digits(25);
        send_byte(et_pkg::CH_SPACE);
        send_word(WORD_BYTES - 1);
        send_byte(et_pkg::CH_SPACE);
        send_word(WORD_BYTES + 2);
        send_byte(et_pkg::CH_SEMI);
        while (bytes_taken < random_start + RANDOM_BYTES) begin
            send_random_token();
            if (!drained_mid && bytes_taken > random_start + RANDOM_BYTES / 2) begin
                wait_for_drain();
                drained_mid = 1'b1;
            end
        end

        // offending high byte halts the lexer; later bytes are dropped
        send_byte(8'($urandom_range(128, 255)));
        repeat (4)
            send_byte(8'($urandom_range(0, 255)));
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (ledger.mismatches == 0 && ledger.pending_tokens.size() == 0)
            $display("tb_expression_tokenizer passed");
        else
            $display("tb_expression_tokenizer failed");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb_expression_tokenizer failed");
        $finish;
    end
endmodule
